// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("%m failed");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("%m failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

// ----- rtl/wppc_pkg.sv -----
// Types and constants shared by the waypoint follower.
package wppc_pkg;
  localparam int CordW = 30;
  localparam int ZW = 20;
  localparam logic signed [ZW-1:0] HalfPiQ16 = 20'sd102944;
  localparam logic signed [16:0] PiQ12 = 17'sd12868;

  localparam logic [0:0] OP_LOAD = 1'b0;
  localparam logic [0:0] OP_POSE = 1'b1;

  localparam logic [2:0] REG_STEER_GAIN = 3'd0;
  localparam logic [2:0] REG_SPEED_GAIN = 3'd1;
  localparam logic [2:0] REG_SPEED_LIMIT = 3'd2;
  localparam logic [2:0] REG_ADVANCE_RADIUS = 3'd3;
  localparam logic [2:0] REG_GOAL_RADIUS = 3'd4;
  localparam logic [2:0] REG_GOAL_X = 3'd5;
  localparam logic [2:0] REG_GOAL_Y = 3'd6;

  function automatic logic [ZW-1:0] atan_entry(input logic [3:0] i);
    case (i)
      4'd0: atan_entry = 20'd51472;
      4'd1: atan_entry = 20'd30386;
      4'd2: atan_entry = 20'd16055;
      4'd3: atan_entry = 20'd8150;
      4'd4: atan_entry = 20'd4091;
      4'd5: atan_entry = 20'd2047;
      4'd6: atan_entry = 20'd1024;
      4'd7: atan_entry = 20'd512;
      4'd8: atan_entry = 20'd256;
      4'd9: atan_entry = 20'd128;
      4'd10: atan_entry = 20'd64;
      4'd11: atan_entry = 20'd32;
      4'd12: atan_entry = 20'd16;
      4'd13: atan_entry = 20'd8;
      4'd14: atan_entry = 20'd4;
      default: atan_entry = 20'd2;
    endcase
  endfunction

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_GOAL,     // start goal distance
    CMD_WAYPOINT, // start waypoint distance on read data
    CMD_FINAL     // start final distance and bearing
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t code;
    logic      latch_pose;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic dist_below_goal;
    logic dist_below_adv;
  } dp_status_t;
endpackage

// ----- rtl/wppc_if.sv -----
// Valid/ready channel interfaces.
interface wppc_in_if;
  logic               valid;
  logic               ready;
  logic [0:0]         op;
  logic [7:0]         waypoint_index;
  logic signed [15:0] waypoint_x;
  logic signed [15:0] waypoint_y;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [14:0] heading;
  modport source (output valid, op, waypoint_index, waypoint_x, waypoint_y, pos_x, pos_y,
                  heading, input ready);
  modport sink (input valid, op, waypoint_index, waypoint_x, waypoint_y, pos_x, pos_y,
                heading, output ready);
endinterface

interface wppc_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        speed;
  logic signed [16:0] turn_rate;
  logic               at_goal;
  logic [7:0]         active_index;
  modport source (output valid, speed, turn_rate, at_goal, active_index, input ready);
  modport sink (input valid, speed, turn_rate, at_goal, active_index, output ready);
endinterface

interface wppc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/waypoint_pursuit_p_controller_core.sv -----
// Waypoint follower: a pose item that does not reach the goal gets its result from
// three serial 17-step square roots (goal, current waypoint, pursued waypoint) and a
// 16-step CORDIC on a shared datapath; a pose that reaches the goal needs only the
// goal square root, one that finds the goal already reached needs none, and a load
// writes the table and sets the pursued index. A result waits in the output register
// and the next item is taken the cycle after it is gone, not while one is in work.
// The waypoint table has no reset; only written entries may be pursued.
module waypoint_pursuit_p_controller_core import wppc_pkg::*; #(
  parameter int WAYPOINT_DEPTH = 256
) (
  input  logic     clk,
  input  logic     rst,
  wppc_in_if.sink  in_ch,
  wppc_out_if.source out_ch,
  wppc_cfg_if.sink cfg
);
  logic [11:0]        steer_gain, speed_gain;
  logic [15:0]        speed_limit, advance_radius, goal_radius;
  logic signed [15:0] goal_x, goal_y;
  dp_cmd_t            cmd;
  dp_status_t         status;
  logic signed [15:0] wp_x, wp_y;
  logic [15:0]        speed;
  logic signed [16:0] turn_rate;
  logic               at_goal;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      steer_gain <= 12'd461;
      speed_gain <= 12'd461;
      speed_limit <= 16'd102;
      advance_radius <= 16'd51;
      goal_radius <= 16'd51;
      goal_x <= 16'sd1280;
      goal_y <= 16'sd1280;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_STEER_GAIN: steer_gain <= cfg.data[11:0];
        REG_SPEED_GAIN: speed_gain <= cfg.data[11:0];
        REG_SPEED_LIMIT: speed_limit <= cfg.data;
        REG_ADVANCE_RADIUS: advance_radius <= cfg.data;
        REG_GOAL_RADIUS: goal_radius <= cfg.data;
        REG_GOAL_X: goal_x <= cfg.data;
        REG_GOAL_Y: goal_y <= cfg.data;
        default: ;
      endcase
    end
  end

  wppc_ctrl #(.WAYPOINT_DEPTH(WAYPOINT_DEPTH)) u_ctrl (
    .clk, .rst, .in_ch,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_at_goal(at_goal), .out_index(out_ch.active_index),
    .cmd, .status, .wp_x, .wp_y
  );

  wppc_datapath u_dp (
    .clk, .rst, .cmd, .status,
    .pos_x(in_ch.pos_x), .pos_y(in_ch.pos_y), .heading(in_ch.heading),
    .goal_x, .goal_y, .wp_x, .wp_y, .goal_radius, .advance_radius,
    .steer_gain, .speed_gain, .speed_limit, .speed, .turn_rate
  );

  assign out_ch.at_goal = at_goal;
  assign out_ch.speed = at_goal ? 16'd0 : speed;
  assign out_ch.turn_rate = at_goal ? 17'sd0 : turn_rate;
endmodule

// ----- rtl/wppc_datapath.sv -----
// Datapath: serial square root, serial CORDIC and output arithmetic.
module wppc_datapath import wppc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_status_t         status,
  input  logic signed [15:0] pos_x,
  input  logic signed [15:0] pos_y,
  input  logic signed [14:0] heading,
  input  logic signed [15:0] goal_x,
  input  logic signed [15:0] goal_y,
  input  logic signed [15:0] wp_x,
  input  logic signed [15:0] wp_y,
  input  logic [15:0]        goal_radius,
  input  logic [15:0]        advance_radius,
  input  logic [11:0]        steer_gain,
  input  logic [11:0]        speed_gain,
  input  logic [15:0]        speed_limit,
  output logic [15:0]        speed,
  output logic signed [16:0] turn_rate
);
  typedef enum logic [2:0] {
    D_IDLE, D_SQ, D_SQRT, D_CORDIC, D_MUL, D_SAT
  } dstate_t;

  dstate_t            dstate;
  cmd_code_t          kind;
  logic signed [15:0] px, py;
  logic signed [14:0] hd;
  logic signed [16:0] dx, dy;
  logic [33:0]        sq_sum;
  logic [33:0]        rem;
  logic [17:0]        root;
  logic [4:0]         sq_cnt;
  logic signed [CordW-1:0] cx, cy;
  logic signed [ZW-1:0]    cz;
  logic [3:0]         ci;
  logic               cordic_done;
  logic [29:0]        spd_prod;
  logic signed [31:0] turn_prod;
  logic signed [16:0] bearing;
  logic signed [16:0] err;

  logic signed [16:0] dx_in, dy_in;
  logic signed [16:0] adx, ady;
  logic [35:0]        trial;
  logic [35:0]        rem_sh;
  logic signed [CordW-1:0] xs, ys;
  logic signed [ZW-1:0]    zr;
  logic signed [32:0]      trnd;

  always_comb begin
    dx_in = 17'sd0;
    dy_in = 17'sd0;
    case (cmd.code)
      CMD_GOAL: begin
        dx_in = 17'(goal_x) - 17'(px);
        dy_in = 17'(goal_y) - 17'(py);
      end
      default: begin
        dx_in = 17'(wp_x) - 17'(px);
        dy_in = 17'(wp_y) - 17'(py);
      end
    endcase
    adx = dx[16] ? -dx : dx;
    ady = dy[16] ? -dy : dy;
    // restoring square root: two radicand bits per step
    rem_sh = {rem, sq_sum[33:32]};
    trial = {16'd0, root, 2'b01};
    xs = cx >>> ci;
    ys = cy >>> ci;
    zr = (cz + 20'sd8) >>> 4;
    trnd = 33'(turn_prod) + 33'sd128;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dstate <= D_IDLE;
      kind <= CMD_NONE;
    end else begin
      if (cmd.latch_pose) begin
        px <= pos_x;
        py <= pos_y;
        hd <= heading;
      end
      case (dstate)
        D_IDLE: begin
          if (cmd.code != CMD_NONE) begin
            kind <= cmd.code;
            dx <= dx_in;
            dy <= dy_in;
            dstate <= D_SQ;
          end
        end
        D_SQ: begin
          sq_sum <= 34'(adx * adx) + 34'(ady * ady);
          rem <= '0;
          root <= '0;
          sq_cnt <= '0;
          dstate <= D_SQRT;
        end
        D_SQRT: begin
          if (rem_sh >= trial) begin
            rem <= 34'(rem_sh - trial);
            root <= {root[16:0], 1'b1};
          end else begin
            rem <= rem_sh[33:0];
            root <= {root[16:0], 1'b0};
          end
          sq_sum <= {sq_sum[31:0], 2'b00};
          sq_cnt <= sq_cnt + 5'd1;
          if (sq_cnt == 5'd16) begin
            if (kind == CMD_FINAL) begin
              // prerotate into the right half plane
              ci <= '0;
              cordic_done <= (dx == 17'sd0) && (dy == 17'sd0);
              if (dx < 0) begin
                if (dy >= 0) begin
                  cx <= CordW'(dy) <<< 8;
                  cy <= -(CordW'(dx) <<< 8);
                  cz <= HalfPiQ16;
                end else begin
                  cx <= -(CordW'(dy) <<< 8);
                  cy <= CordW'(dx) <<< 8;
                  cz <= -HalfPiQ16;
                end
              end else begin
                cx <= CordW'(dx) <<< 8;
                cy <= CordW'(dy) <<< 8;
                cz <= '0;
              end
              dstate <= D_CORDIC;
            end else begin
              dstate <= D_IDLE;
            end
          end
        end
        D_CORDIC: begin
          if (!cordic_done) begin
            if (cy >= 0) begin
              cx <= cx + ys;
              cy <= cy - xs;
              cz <= cz + atan_entry(ci);
            end else begin
              cx <= cx - ys;
              cy <= cy + xs;
              cz <= cz - atan_entry(ci);
            end
          end
          ci <= ci + 4'd1;
          if (ci == 4'd15) begin
            dstate <= D_MUL;
          end
        end
        D_MUL: begin
          spd_prod <= 30'(root) * 30'(speed_gain);
          turn_prod <= $signed({1'b0, steer_gain}) * 32'(err);
          dstate <= D_SAT;
        end
        D_SAT: begin
          if (spd_prod[29:8] > 22'(speed_limit)) speed <= speed_limit;
          else speed <= spd_prod[23:8];
          if ((trnd >>> 8) > 33'sd65535) turn_rate <= 17'sd65535;
          else if ((trnd >>> 8) < -33'sd65536) turn_rate <= -17'sd65536;
          else turn_rate <= 17'(trnd >>> 8);
          dstate <= D_IDLE;
        end
        default: dstate <= D_IDLE;
      endcase
    end
  end

  always_comb begin
    if (cordic_done) bearing = '0;
    else if (zr > ZW'(PiQ12)) bearing = PiQ12;
    else if (zr < -ZW'(PiQ12)) bearing = -PiQ12;
    else bearing = 17'(zr);
    err = bearing - 17'(hd);
  end

  assign status.busy = (dstate != D_IDLE);
  assign status.dist_below_goal = (20'(root) < 20'(goal_radius));
  assign status.dist_below_adv = (20'(root) < 20'(advance_radius));

  `include "assert_macros.svh"
  `ASSERT_NEXT(a_start_busy, clk, rst, (dstate == D_IDLE) && (cmd.code != CMD_NONE), dstate == D_SQ)
  `ASSERT_NEXT(a_sq_to_sqrt, clk, rst, dstate == D_SQ, dstate == D_SQRT)
  `ASSERT_IMPLIES(a_cmd_idle, clk, rst, cmd.code != CMD_NONE, dstate == D_IDLE)
endmodule

// ----- rtl/wppc_ctrl.sv -----
// Controller: sequences items, holds table, index and arrival state.
module wppc_ctrl import wppc_pkg::*; #(
  parameter int WAYPOINT_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  wppc_in_if.sink    in_ch,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_at_goal,
  output logic [7:0] out_index,
  output dp_cmd_t    cmd,
  input  dp_status_t status,
  output logic signed [15:0] wp_x,
  output logic signed [15:0] wp_y
);
  localparam int IW = (WAYPOINT_DEPTH > 1) ? $clog2(WAYPOINT_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_GOAL, S_READ, S_WP, S_READ2, S_FINAL, S_OUT
  } state_t;

  state_t      state;
  logic [31:0] table_mem [WAYPOINT_DEPTH];
  logic [31:0] rd_data;
  logic [IW-1:0] rd_addr;
  logic [7:0]  cur_index;
  logic        arrived;
  logic        started;
  logic        in_range;
  cmd_code_t   cmd_code;
  logic        pose_take;

  assign in_range = (32'(in_ch.waypoint_index) < 32'(WAYPOINT_DEPTH));
  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign wp_x = rd_data[31:16];
  assign wp_y = rd_data[15:0];
  // capture the pose on the accepting edge, while the payload is still valid
  assign pose_take = in_ch.valid && in_ch.ready && (in_ch.op == OP_POSE);
  assign cmd = '{cmd_code, pose_take};

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready && (in_ch.op == OP_LOAD) && in_range)
      table_mem[IW'(in_ch.waypoint_index)] <= {in_ch.waypoint_x, in_ch.waypoint_y};
    rd_data <= table_mem[rd_addr];
  end

  always_comb begin
    rd_addr = IW'(cur_index);
    if (state == S_WP && status.dist_below_adv && cur_index != 8'd0)
      rd_addr = IW'(cur_index - 8'd1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cur_index <= '0;
      arrived <= 1'b0;
      out_valid <= 1'b0;
      out_at_goal <= 1'b0;
      out_index <= '0;
      cmd_code <= CMD_NONE;
      started <= 1'b0;
    end else begin
      cmd_code <= CMD_NONE;
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            if (in_ch.op == OP_LOAD) begin
              if (in_range) begin
                cur_index <= in_ch.waypoint_index;
                arrived <= 1'b0;
              end
            end else if (arrived) begin
              out_at_goal <= 1'b1;
              out_index <= cur_index;
              state <= S_OUT;
            end else begin
              state <= S_GOAL;
              started <= 1'b0;
            end
          end
        end
        S_GOAL: begin
          if (!started) begin
            cmd_code <= CMD_GOAL;
            started <= 1'b1;
          end else if (!status.busy && cmd_code == CMD_NONE) begin
            started <= 1'b0;
            if (status.dist_below_goal) begin
              arrived <= 1'b1;
              out_at_goal <= 1'b1;
              out_index <= cur_index;
              state <= S_OUT;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          // wait in this state for registered read data
          cmd_code <= CMD_WAYPOINT;
          state <= S_WP;
        end
        S_WP: begin
          if (!status.busy && cmd_code == CMD_NONE) begin
            if (status.dist_below_adv && cur_index != 8'd0)
              cur_index <= cur_index - 8'd1;
            state <= S_READ2;
          end
        end
        S_READ2: begin
          state <= S_FINAL;
          started <= 1'b0;
        end
        S_FINAL: begin
          if (!started) begin
            cmd_code <= CMD_FINAL;
            started <= 1'b1;
          end else if (!status.busy && cmd_code == CMD_NONE) begin
            out_at_goal <= 1'b0;
            out_index <= cur_index;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `include "assert_macros.svh"
  `ASSERT_IMPLIES(a_ready_idle, clk, rst, in_ch.ready, state == S_IDLE)
  `ASSERT_NEXT(a_out_from_state, clk, rst, state == S_OUT, out_valid)
  `ASSERT_IMPLIES(a_goal_zero_index, clk, rst, out_valid && out_at_goal, arrived)
endmodule

// ----- bench/tb_waypoint_pursuit_p_controller_core.sv -----
// Testbench for the waypoint follower core: directed and random pose/load traffic.
module tb_waypoint_pursuit_p_controller_core;
  import wppc_pkg::*;

  typedef struct {
    logic [15:0]        speed;
    logic signed [16:0] turn_rate;
    logic               at_goal;
    logic [7:0]         active_index;
  } command_t;

  logic clk;
  logic rst;
  int   errors;
  int   poses_sent;
  int   loads_sent;
  int   commands_seen;
  int   src_idle_pct;
  int   dst_stall_pct;
  bit   hold_receiver;

  wppc_in_if  in_ch ();
  wppc_out_if out_ch ();
  wppc_cfg_if cfg ();

  waypoint_pursuit_p_controller_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  // Predictor state
  logic signed [15:0] path_x [256];
  logic signed [15:0] path_y [256];
  logic [7:0]         pursuit_index;
  bit                 goal_reached;
  logic [11:0]        steer_gain_r;
  logic [11:0]        speed_gain_r;
  logic [15:0]        speed_limit_r;
  logic [15:0]        advance_radius_r;
  logic [15:0]        goal_radius_r;
  logic signed [15:0] goal_x_r;
  logic signed [15:0] goal_y_r;
  command_t           pending_commands [$];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50000000;
    $display("tb_waypoint_pursuit_p_controller_core NOT OK");
    $finish;
  end

  function automatic longint floor_shift(longint v, int s);
    if (v >= 0) return v >>> s;
    return -(((-v) - 1) >>> s) - 1;
  endfunction

  function automatic longint range_q8(longint dx, longint dy);
    longint unsigned v;
    longint unsigned r;
    longint unsigned b;
    v = dx * dx + dy * dy;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return longint'(r);
  endfunction

  function automatic longint bearing_q12(longint dy, longint dx);
    longint x;
    longint y;
    longint z;
    longint t;
    longint xs;
    longint ys;
    longint angles [16];
    angles = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
               256, 128, 64, 32, 16, 8, 4, 2};
    if (dx == 0 && dy == 0) return 0;
    x = dx * 256;
    y = dy * 256;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 102944;
      end else begin
        t = x; x = -y; y = t; z = -102944;
      end
    end
    for (int i = 0; i < 16; i++) begin
      xs = floor_shift(x, i);
      ys = floor_shift(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + angles[i];
      end else begin
        x = x - ys; y = y + xs; z = z - angles[i];
      end
    end
    z = floor_shift(z + 8, 4);
    if (z > 12868) z = 12868;
    if (z < -12868) z = -12868;
    return z;
  endfunction

  function automatic void predict_pose(logic signed [15:0] px, logic signed [15:0] py,
                                       logic signed [14:0] hd);
    command_t c;
    longint   wx;
    longint   wy;
    longint   d;
    longint   spd;
    longint   turn;
    if (!goal_reached &&
        range_q8(longint'(goal_x_r) - px, longint'(goal_y_r) - py) < goal_radius_r)
      goal_reached = 1;
    if (goal_reached) begin
      c.speed = '0;
      c.turn_rate = '0;
      c.at_goal = 1'b1;
      c.active_index = pursuit_index;
      pending_commands.push_back(c);
      return;
    end
    wx = path_x[pursuit_index];
    wy = path_y[pursuit_index];
    if (range_q8(wx - px, wy - py) < advance_radius_r && pursuit_index > 0) begin
      pursuit_index = pursuit_index - 1;
      wx = path_x[pursuit_index];
      wy = path_y[pursuit_index];
    end
    d = range_q8(wx - px, wy - py);
    spd = (longint'(speed_gain_r) * d) >>> 8;
    if (spd > speed_limit_r) spd = speed_limit_r;
    turn = floor_shift(longint'(steer_gain_r) * (bearing_q12(wy - py, wx - px) - hd) + 128, 8);
    if (turn > 65535) turn = 65535;
    if (turn < -65536) turn = -65536;
    c.speed = spd[15:0];
    c.turn_rate = turn[16:0];
    c.at_goal = 1'b0;
    c.active_index = pursuit_index;
    pending_commands.push_back(c);
  endfunction

  // Drive one transaction, update the prediction when it is accepted.
  // Valid stays high into the next transaction; idle cycles and drain drop it.
  task automatic send_item(logic [0:0] op, logic [7:0] idx, logic signed [15:0] wx,
                           logic signed [15:0] wy, logic signed [15:0] px,
                           logic signed [15:0] py, logic signed [14:0] hd);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.waypoint_index <= idx;
    in_ch.waypoint_x <= wx;
    in_ch.waypoint_y <= wy;
    in_ch.pos_x <= px;
    in_ch.pos_y <= py;
    in_ch.heading <= hd;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_LOAD) begin
      path_x[idx] = wx;
      path_y[idx] = wy;
      pursuit_index = idx;
      goal_reached = 0;
      loads_sent++;
    end else begin
      predict_pose(px, py, hd);
      poses_sent++;
    end
  endtask

  task automatic load_point(logic [7:0] idx, logic signed [15:0] wx, logic signed [15:0] wy);
    send_item(OP_LOAD, idx, wx, wy, 16'($urandom), 16'($urandom), 15'($urandom));
  endtask

  task automatic pose(logic signed [15:0] px, logic signed [15:0] py, logic signed [14:0] hd);
    send_item(OP_POSE, 8'($urandom), 16'($urandom), 16'($urandom), px, py, hd);
  endtask

  function automatic logic signed [14:0] rand_heading();
    // mostly within plus or minus pi, sometimes any 15-bit value
    if ($urandom_range(9) == 0) return 15'($urandom);
    return 15'($signed($urandom_range(25736)) - 12868);
  endfunction

  task automatic drain();
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (pending_commands.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= value;
    @(posedge clk);
    while (!cfg.ready) @(posedge clk);
    case (idx)
      REG_STEER_GAIN:     steer_gain_r = value[11:0];
      REG_SPEED_GAIN:     speed_gain_r = value[11:0];
      REG_SPEED_LIMIT:    speed_limit_r = value;
      REG_ADVANCE_RADIUS: advance_radius_r = value;
      REG_GOAL_RADIUS:    goal_radius_r = value;
      REG_GOAL_X:         goal_x_r = value;
      default:            goal_y_r = value;
    endcase
  endtask

  task automatic set_all(logic [11:0] sg, logic [11:0] vg, logic [15:0] lim, logic [15:0] adv,
                         logic [15:0] gr, logic [15:0] gx, logic [15:0] gy);
    drain();
    write_reg(REG_STEER_GAIN, {4'd0, sg});
    write_reg(REG_SPEED_GAIN, {4'd0, vg});
    write_reg(REG_SPEED_LIMIT, lim);
    write_reg(REG_ADVANCE_RADIUS, adv);
    write_reg(REG_GOAL_RADIUS, gr);
    write_reg(REG_GOAL_X, gx);
    write_reg(REG_GOAL_Y, gy);
    cfg.valid <= 1'b0;
  endtask

  // Output checker
  always @(posedge clk) begin
    command_t e;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        commands_seen++;
        if (pending_commands.size() == 0) begin
          $error("unexpected command transaction");
          errors++;
        end else begin
          e = pending_commands.pop_front();
          if (out_ch.speed !== e.speed) begin
            $error("speed exp %0d got %0d", e.speed, out_ch.speed);
            errors++;
          end
          if (out_ch.turn_rate !== e.turn_rate) begin
            $error("turn_rate exp %0d got %0d", e.turn_rate, out_ch.turn_rate);
            errors++;
          end
          if (out_ch.at_goal !== e.at_goal) begin
            $error("at_goal exp %0d got %0d", e.at_goal, out_ch.at_goal);
            errors++;
          end
          if (out_ch.active_index !== e.active_index) begin
            $error("active_index exp %0d got %0d", e.active_index, out_ch.active_index);
            errors++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    out_ch.ready <= !hold_receiver && ($urandom_range(99) >= dst_stall_pct);
  end

  task automatic test_extremes();
    // full-range corner path: first entry zero, extremes in coordinates
    load_point(8'd0, 16'sh7fff, 16'sh8000);
    pose(16'sh8000, 16'sh7fff, 15'sd12868);
    pose(16'sh8000, 16'sh8000, -15'sd12868);
    pose(16'sh7fff, 16'sh8000, 15'sh3fff);
    pose(16'sh7fff, 16'sh8000, 15'sh4000);
    load_point(8'd1, 16'sh8000, 16'sh7fff);
    pose(16'sh8000, 16'sh7fff, 15'sd0);
    pose(16'sh7fff, 16'sh7fff, 15'sd100);
    load_point(8'd1, 16'sd0, 16'sd0);
    pose(16'sd0, 16'sd0, 15'sd0);
    pose(16'sd10, 16'sd0, 15'sd0);
    pose(-16'sd10, 16'sd0, 15'sd0);
    pose(16'sd0, -16'sd10, 15'sd0);
    pose(16'sd1280, 16'sd1280, 15'sd0);
    pose(16'sd0, 16'sd0, 15'sd0);
    load_point(8'd2, 16'sd0, 16'sd0);
  endtask

  task automatic test_config_extremes();
    set_all(12'hfff, 12'hfff, 16'hffff, 16'hffff, 16'd0, 16'h8000, 16'h7fff);
    load_point(8'd3, 16'sh7fff, 16'sh7fff);
    pose(16'sh8000, 16'sh8000, 15'sh4000);
    pose(16'sh8000, 16'sh8000, 15'sh3fff);
    set_all(12'd0, 12'd0, 16'd0, 16'd0, 16'hffff, 16'h0, 16'h0);
    pose(16'sd5, 16'sd5, 15'sd5);
    load_point(8'd4, 16'sd100, 16'sd100);
    set_all(12'd461, 12'd461, 16'd102, 16'd51, 16'd51, 16'd1280, 16'd1280);
  endtask

  // Paths loaded as a chain, then poses walked along and around it.
  task automatic random_runs(int n_items);
    int count;
    int top;
    int k;
    logic signed [15:0] bx;
    logic signed [15:0] by;
    count = 0;
    while (count < n_items) begin
      top = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 8);
      bx = 16'($urandom);
      by = 16'($urandom);
      for (int i = 0; i <= top; i++) begin
        load_point(8'(i), bx + 16'($signed($urandom_range(600)) - 300),
                   by + 16'($signed($urandom_range(600)) - 300));
        count++;
      end
      k = $urandom_range(4, 20);
      for (int j = 0; j < k; j++) begin
        if ($urandom_range(3) == 0)
          pose(16'($urandom), 16'($urandom), rand_heading());
        else if ($urandom_range(3) == 0)
          pose(path_x[pursuit_index] + 16'($signed($urandom_range(80)) - 40),
               path_y[pursuit_index] + 16'($signed($urandom_range(80)) - 40),
               rand_heading());
        else
          pose(bx + 16'($signed($urandom_range(800)) - 400),
               by + 16'($signed($urandom_range(800)) - 400), rand_heading());
        count++;
      end
      if ($urandom_range(7) == 0) begin
        goal_x_r = goal_x_r;
        pose(goal_x_r + 16'sd1, goal_y_r, rand_heading());
        count++;
      end
    end
  endtask

  task automatic test_random();
    random_runs(120);
    src_idle_pct = 62;
    random_runs(120);
    src_idle_pct = 0;
    dst_stall_pct = 62;
    random_runs(120);
    src_idle_pct = 10;
    dst_stall_pct = 10;
    random_runs(120);
    src_idle_pct = 0;
    dst_stall_pct = 0;
    set_all(12'd2000, 12'd3000, 16'd40000, 16'd400, 16'd20, 16'hf000, 16'h0800);
    random_runs(150);
    set_all(12'($urandom), 12'($urandom), 16'($urandom), 16'($urandom_range(2000)),
            16'($urandom_range(300)), 16'($urandom), 16'($urandom));
    src_idle_pct = 30;
    dst_stall_pct = 30;
    random_runs(150);
    src_idle_pct = 0;
    dst_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    drain();
    fork
      begin
        hold_receiver = 1;
        repeat (3000) @(posedge clk);
        hold_receiver = 0;
      end
      random_runs(30);
    join
    drain();
  endtask

  initial begin
    errors = 0;
    poses_sent = 0;
    loads_sent = 0;
    commands_seen = 0;
    src_idle_pct = 0;
    dst_stall_pct = 0;
    hold_receiver = 0;
    steer_gain_r = 12'd461;
    speed_gain_r = 12'd461;
    speed_limit_r = 16'd102;
    advance_radius_r = 16'd51;
    goal_radius_r = 16'd51;
    goal_x_r = 16'sd1280;
    goal_y_r = 16'sd1280;
    pursuit_index = '0;
    goal_reached = 0;
    for (int i = 0; i < 256; i++) begin
      path_x[i] = '0;
      path_y[i] = '0;
    end
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.op = OP_LOAD;
    in_ch.waypoint_index = '0;
    in_ch.waypoint_x = '0;
    in_ch.waypoint_y = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    in_ch.heading = '0;
    out_ch.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = REG_STEER_GAIN;
    cfg.data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_extremes();
    test_config_extremes();
    test_random();
    test_backpressure();
    drain();
    $display("covered %0d pose and %0d load transactions, %0d commands checked",
             poses_sent, loads_sent, commands_seen);
    $display("phases: idle mixes, register extremes, long output hold-off");
    if (errors == 0 && pending_commands.size() == 0) begin
      $display("tb_waypoint_pursuit_p_controller_core OK");
    end else begin
      $display("tb_waypoint_pursuit_p_controller_core NOT OK");
    end
    $finish;
  end
endmodule
